[sv/uvs_pkg.sv]
// uvs_pkg: shared types, constants and helper functions of the uv sphere generator
// no dependencies; imported by every module of the block

package uvs_pkg;

  // field and register widths
  localparam int unsigned TRIG_BITS_DEF = 10;
  localparam int unsigned ELEM_W        = 17;
  localparam int unsigned POS_W         = 17;
  localparam int unsigned IDX_W         = 16;
  localparam int unsigned CNT_W         = 8;
  localparam int unsigned RAD_W         = 16;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 16;

  // cordic datapath
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned CORDIC_W     = 34;
  localparam int unsigned Q15_W        = 16;
  localparam int unsigned TRIG_LANES   = 3;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [Q15_W-1:0] Q15_MAX = 16'sd32767;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLICES = 2'd0,
    REG_STACKS = 2'd1,
    REG_RADIUS = 2'd2
  } cfg_reg_e;

  localparam logic [CNT_W-1:0] SLICES_RST = 8'd16;
  localparam logic [CNT_W-1:0] STACKS_RST = 8'd8;
  localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;

  typedef struct packed {
    logic [CNT_W-1:0] slices;
    logic [CNT_W-1:0] stacks;
    logic [RAD_W-1:0] radius;
  } cfg_t;

  // front-end classification of a request
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_VTOP,
    CLS_VBOT,
    CLS_VRING,
    CLS_VDUP,
    CLS_TTOP,
    CLS_TBAND,
    CLS_TBOT
  } cls_e;

  // what the back end has to emit
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_TOP,
    KIND_BOT,
    KIND_RING,
    KIND_TRI
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] corner_a;
    logic [IDX_W-1:0] corner_b;
    logic [IDX_W-1:0] corner_c;
  } tag_t;

  // arctangent of 2^-k in units of 2^-32 turns
  function automatic logic [31:0] atan_turn(input int unsigned k);
    logic [31:0] a;
    unique case (k)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

  // round half up from q4.30 to q1.15 and saturate symmetrically
  function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] t;
    logic signed [Q15_W-1:0]    r;
    t = (v + (34'sd1 <<< 14)) >>> 15;
    if (t > CORDIC_W'(Q15_MAX)) begin
      r = Q15_MAX;
    end else if (t < -CORDIC_W'(Q15_MAX)) begin
      r = -Q15_MAX;
    end else begin
      r = t[Q15_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/uvs_div.sv]
// uvs_div: pipelined restoring divider, one quotient bit per stage, several lanes
// depends on uvs_pkg for the default widths; used by uvs_front

module uvs_div #(
  parameter int unsigned LANES = 1,
  parameter int unsigned NUM_W = uvs_pkg::ELEM_W,
  parameter int unsigned DEN_W = uvs_pkg::CNT_W + 1,
  parameter int unsigned TAG_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [LANES-1:0][NUM_W-1:0]   num_i,
  input  logic [LANES-1:0][DEN_W-1:0]   den_i,
  input  logic [TAG_W-1:0]              tag_i,
  output logic                          out_valid_o,
  output logic [LANES-1:0][NUM_W-1:0]   quo_o,
  output logic [LANES-1:0][DEN_W-1:0]   rem_o,
  output logic [TAG_W-1:0]              tag_o
);
  import uvs_pkg::*;

  logic                        valid_q [NUM_W];
  logic [LANES-1:0][NUM_W-1:0] num_q   [NUM_W];
  logic [LANES-1:0][DEN_W-1:0] den_q   [NUM_W];
  logic [LANES-1:0][DEN_W-1:0] rem_q   [NUM_W];
  logic [TAG_W-1:0]            tag_q   [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic                        v_in;
    logic [LANES-1:0][NUM_W-1:0] n_in;
    logic [LANES-1:0][DEN_W-1:0] d_in;
    logic [LANES-1:0][DEN_W-1:0] r_in;
    logic [TAG_W-1:0]            t_in;
    logic [LANES-1:0][NUM_W-1:0] n_d;
    logic [LANES-1:0][DEN_W-1:0] r_d;

    if (k == 0) begin : g_first
      assign v_in = in_valid_i;
      assign n_in = num_i;
      assign d_in = den_i;
      assign r_in = '0;
      assign t_in = tag_i;
    end else begin : g_next
      assign v_in = valid_q[k-1];
      assign n_in = num_q[k-1];
      assign d_in = den_q[k-1];
      assign r_in = rem_q[k-1];
      assign t_in = tag_q[k-1];
    end

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
      logic [DEN_W:0] trial;
      logic           take;
      for (int l = 0; l < LANES; l++) begin
        trial = {r_in[l], n_in[l][NUM_W-1]};
        take  = trial >= {1'b0, d_in[l]};
        if (take) begin
          r_d[l] = DEN_W'(trial - {1'b0, d_in[l]});
        end else begin
          r_d[l] = trial[DEN_W-1:0];
        end
        n_d[l] = {n_in[l][NUM_W-2:0], take};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[k] <= n_d;
      rem_q[k] <= r_d;
      den_q[k] <= d_in;
      tag_q[k] <= t_in;
    end
  end

  assign out_valid_o = valid_q[NUM_W-1];
  assign quo_o       = num_q[NUM_W-1];
  assign rem_o       = rem_q[NUM_W-1];
  assign tag_o       = tag_q[NUM_W-1];

endmodule

[sv/uvs_front.sv]
// uvs_front: classifies requests, splits element numbers into ring and slice,
// works out triangle corners and the quantised angles; depends on uvs_pkg, uvs_div

module uvs_front #(
  parameter int unsigned TRIG_BITS = uvs_pkg::TRIG_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           in_valid_i,
  input  logic                                           op_i,
  input  logic [uvs_pkg::ELEM_W-1:0]                     elem_i,
  input  uvs_pkg::cfg_t                                  cfg_i,
  output logic                                           out_valid_o,
  output uvs_pkg::tag_t                                  out_tag_o,
  output logic [uvs_pkg::TRIG_LANES-1:0][TRIG_BITS-1:0]  out_phase_o
);
  import uvs_pkg::*;

  localparam int unsigned DEN_W    = CNT_W + 1;
  localparam int unsigned PH_NUM_W = TRIG_BITS + CNT_W + 1;
  localparam int unsigned CLS_W    = $bits(cls_e);
  localparam int unsigned TAG_W    = $bits(tag_t);

  // mesh sizes from the current configuration
  logic [15:0]       s16, n16, ring_span, band_span;
  logic [ELEM_W-1:0] n_vert, bottom, tri_total, band_tris;
  logic              mesh_ok;

  always_comb begin
    s16       = {8'h00, cfg_i.slices};
    n16       = {8'h00, cfg_i.stacks};
    ring_span = (n16 - 16'd1) * s16;
    band_span = (n16 - 16'd2) * s16;
    n_vert    = {1'b0, 16'(n16 * s16)} + 17'd2;
    bottom    = {1'b0, ring_span} + 17'd1;
    tri_total = {ring_span, 1'b0};
    band_tris = {band_span, 1'b0};
    mesh_ok   = (cfg_i.slices >= 8'd3) && (cfg_i.stacks >= 8'd2);
  end

  // classify and pick the numerator for the slice split
  cls_e              a_cls;
  logic [ELEM_W-1:0] a_num;
  logic [DEN_W-1:0]  a_den;
  logic [ELEM_W-1:0] e_minus_s;

  always_comb begin
    e_minus_s = elem_i - {9'h000, cfg_i.slices};
    a_cls     = CLS_NONE;
    a_num     = '0;
    a_den     = op_i ? {cfg_i.slices, 1'b0} : {1'b0, cfg_i.slices};
    priority if (!mesh_ok) begin
      a_cls = CLS_NONE;
    end else if (!op_i) begin
      priority if (elem_i >= n_vert) begin
        a_cls = CLS_NONE;
      end else if (elem_i == '0) begin
        a_cls = CLS_VTOP;
      end else if (elem_i < bottom) begin
        a_cls = CLS_VRING;
        a_num = elem_i - 17'd1;
      end else if (elem_i == bottom) begin
        a_cls = CLS_VBOT;
      end else begin
        a_cls = CLS_VDUP;
        a_num = elem_i - bottom - 17'd1;
      end
    end else begin
      priority if (elem_i >= tri_total) begin
        a_cls = CLS_NONE;
      end else if (elem_i < {9'h000, cfg_i.slices}) begin
        a_cls = CLS_TTOP;
        a_num = elem_i;
      end else if (e_minus_s < band_tris) begin
        a_cls = CLS_TBAND;
        a_num = e_minus_s;
      end else begin
        a_cls = CLS_TBOT;
        a_num = e_minus_s - band_tris;
      end
    end
  end

  // ring / slice split
  logic                          d1_valid;
  logic [0:0][ELEM_W-1:0]        d1_quo;
  logic [0:0][DEN_W-1:0]         d1_rem;
  logic [CLS_W-1:0]              d1_tag;

  uvs_div #(
    .LANES (1),
    .NUM_W (ELEM_W),
    .DEN_W (DEN_W),
    .TAG_W (CLS_W)
  ) u_split_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .num_i       (a_num),
    .den_i       (a_den),
    .tag_i       (a_cls),
    .out_valid_o (d1_valid),
    .quo_o       (d1_quo),
    .rem_o       (d1_rem),
    .tag_o       (d1_tag)
  );

  // corners, ring numbers and angle numerators
  cls_e                                  b_cls;
  logic [CNT_W-1:0]                      q8, s_m1, j_band, i_band, i_cap, lon_i, jy, jr;
  logic [15:0]                           base16;
  logic [ELEM_W-1:0]                     band_base, v_band, pole, c_a, c_b, c_c;
  logic                                  last_band, last_cap;
  tag_t                                  b_tag;
  logic [TRIG_LANES-1:0][PH_NUM_W-1:0]   b_num;
  logic [TRIG_LANES-1:0][DEN_W-1:0]      b_den;

  always_comb begin
    b_cls     = cls_e'(d1_tag);
    q8        = d1_quo[0][CNT_W-1:0];
    s_m1      = cfg_i.slices - 8'd1;
    j_band    = q8 + 8'd2;
    i_band    = d1_rem[0][DEN_W-1:1];
    i_cap     = d1_rem[0][CNT_W-1:0];
    base16    = ({8'h00, j_band} - 16'd1) * s16;
    band_base = {1'b0, base16} + 17'd1;
    v_band    = band_base + {9'h000, i_band};
    pole      = bottom;
    last_band = i_band == s_m1;
    last_cap  = i_cap == s_m1;
    c_a       = '0;
    c_b       = '0;
    c_c       = '0;
    lon_i     = i_cap;
    jy        = q8 + 8'd1;
    jr        = q8 + 8'd1;
    b_tag.kind = KIND_NONE;
    unique case (b_cls)
      CLS_VTOP:  b_tag.kind = KIND_TOP;
      CLS_VBOT:  b_tag.kind = KIND_BOT;
      CLS_VRING: b_tag.kind = KIND_RING;
      CLS_VDUP: begin
        b_tag.kind = KIND_RING;
        jy         = cfg_i.stacks - 8'd1;
        jr         = 8'd1;
      end
      CLS_TTOP: begin
        b_tag.kind = KIND_TRI;
        c_b        = {9'h000, i_cap} + 17'd1;
        c_c        = last_cap ? 17'd1 : {9'h000, i_cap} + 17'd2;
      end
      CLS_TBAND: begin
        b_tag.kind = KIND_TRI;
        c_c        = last_band ? band_base : v_band + 17'd1;
        if (!d1_rem[0][0]) begin
          c_a = v_band - {9'h000, cfg_i.slices};
          c_b = v_band;
        end else begin
          c_a = last_band ? band_base - {9'h000, cfg_i.slices}
                          : v_band - {9'h000, cfg_i.slices} + 17'd1;
          c_b = v_band - {9'h000, cfg_i.slices};
        end
      end
      CLS_TBOT: begin
        b_tag.kind = KIND_TRI;
        c_a        = pole;
        c_b        = last_cap ? pole + 17'd1 : pole + {9'h000, i_cap} + 17'd2;
        c_c        = pole + {9'h000, i_cap} + 17'd1;
      end
      default:   b_tag.kind = KIND_NONE;
    endcase
    b_tag.corner_a = c_a[IDX_W-1:0];
    b_tag.corner_b = c_b[IDX_W-1:0];
    b_tag.corner_c = c_c[IDX_W-1:0];
    // longitude: (i * 2^(bits+1) + S) / 2S; latitude: (j * 2^bits + N) / 2N
    b_num[0] = {lon_i, {(TRIG_BITS + 1){1'b0}}}
             + {{(TRIG_BITS + 1){1'b0}}, cfg_i.slices};
    b_num[1] = {1'b0, jy, {TRIG_BITS{1'b0}}}
             + {{(TRIG_BITS + 1){1'b0}}, cfg_i.stacks};
    b_num[2] = {1'b0, jr, {TRIG_BITS{1'b0}}}
             + {{(TRIG_BITS + 1){1'b0}}, cfg_i.stacks};
    b_den[0] = {cfg_i.slices, 1'b0};
    b_den[1] = {cfg_i.stacks, 1'b0};
    b_den[2] = {cfg_i.stacks, 1'b0};
  end

  logic                                b_valid_q;
  tag_t                                b_tag_q;
  logic [TRIG_LANES-1:0][PH_NUM_W-1:0] b_num_q;
  logic [TRIG_LANES-1:0][DEN_W-1:0]    b_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= d1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    b_tag_q <= b_tag;
    b_num_q <= b_num;
    b_den_q <= b_den;
  end

  // angle quantisation
  logic [TRIG_LANES-1:0][PH_NUM_W-1:0] d2_quo;
  logic [TRIG_LANES-1:0][DEN_W-1:0]    d2_rem;
  logic [TAG_W-1:0]                    d2_tag;

  uvs_div #(
    .LANES (TRIG_LANES),
    .NUM_W (PH_NUM_W),
    .DEN_W (DEN_W),
    .TAG_W (TAG_W)
  ) u_phase_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid_q),
    .num_i       (b_num_q),
    .den_i       (b_den_q),
    .tag_i       (b_tag_q),
    .out_valid_o (out_valid_o),
    .quo_o       (d2_quo),
    .rem_o       (d2_rem),
    .tag_o       (d2_tag)
  );

  // keep the phase modulo one turn
  always_comb begin
    for (int l = 0; l < TRIG_LANES; l++) begin
      out_phase_o[l] = d2_quo[l][TRIG_BITS-1:0];
    end
  end

  assign out_tag_o = tag_t'(d2_tag);

endmodule

[sv/uvs_queue.sv]
// uvs_queue: short fifo between the front and back halves
// depends on uvs_pkg for the default depth

module uvs_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = uvs_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              ready_i,
  output logic              out_valid_o,
  output logic [DATA_W-1:0] data_o
);
  import uvs_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]    count_q, count_d;
  logic              push, pop;

  // pointer and fill bookkeeping
  always_comb begin
    push     = push_i && (count_q != (PTR_W + 1)'(DEPTH));
    pop      = out_valid_o && ready_i;
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign out_valid_o = count_q != '0;
  assign data_o      = mem_q[rd_ptr_q];

endmodule

[sv/uvs_cordic.sv]
// uvs_cordic: three-lane pipelined rotation cordic giving q1.15 sine and cosine
// depends on uvs_pkg (gain, arctangent steps, rounding)

module uvs_cordic #(
  parameter int unsigned TRIG_BITS = uvs_pkg::TRIG_BITS_DEF,
  parameter int unsigned TAG_W     = 1
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              in_valid_i,
  input  logic [uvs_pkg::TRIG_LANES-1:0][TRIG_BITS-1:0]     phase_i,
  input  logic [TAG_W-1:0]                                  tag_i,
  output logic                                              out_valid_o,
  output logic [uvs_pkg::TRIG_LANES-1:0][uvs_pkg::Q15_W-1:0] sin_o,
  output logic [uvs_pkg::TRIG_LANES-1:0][uvs_pkg::Q15_W-1:0] cos_o,
  output logic [TAG_W-1:0]                                  tag_o
);
  import uvs_pkg::*;

  logic                       valid_q [CORDIC_STEPS+1];
  logic [TAG_W-1:0]           tag_q   [CORDIC_STEPS+1];
  logic [TRIG_LANES-1:0]      flip_q  [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] x_q     [CORDIC_STEPS+1][TRIG_LANES];
  logic signed [CORDIC_W-1:0] y_q     [CORDIC_STEPS+1][TRIG_LANES];
  logic signed [CORDIC_W-1:0] r_q     [CORDIC_STEPS+1][TRIG_LANES];

  // fold the angle into the right half plane
  logic [TRIG_LANES-1:0]      pre_flip;
  logic signed [CORDIC_W-1:0] pre_r [TRIG_LANES];

  always_comb begin
    logic [31:0] z;
    logic [31:0] zf;
    for (int l = 0; l < TRIG_LANES; l++) begin
      z           = {phase_i[l], {(32 - TRIG_BITS){1'b0}}};
      pre_flip[l] = z[31] ^ z[30];
      zf          = {z[31] ^ pre_flip[l], z[30:0]};
      pre_r[l]    = {{(CORDIC_W - 32){zf[31]}}, zf};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0]  <= tag_i;
    flip_q[0] <= pre_flip;
    for (int l = 0; l < TRIG_LANES; l++) begin
      x_q[0][l] <= CORDIC_GAIN;
      y_q[0][l] <= '0;
      r_q[0][l] <= pre_r[l];
    end
  end

  // one micro-rotation per stage
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    logic signed [CORDIC_W-1:0] atan_k;
    logic signed [CORDIC_W-1:0] x_d [TRIG_LANES];
    logic signed [CORDIC_W-1:0] y_d [TRIG_LANES];
    logic signed [CORDIC_W-1:0] r_d [TRIG_LANES];

    assign atan_k = {{(CORDIC_W - 32){1'b0}}, atan_turn(k)};

    always_comb begin
      for (int l = 0; l < TRIG_LANES; l++) begin
        if (!r_q[k][l][CORDIC_W-1]) begin
          x_d[l] = x_q[k][l] - (y_q[k][l] >>> k);
          y_d[l] = y_q[k][l] + (x_q[k][l] >>> k);
          r_d[l] = r_q[k][l] - atan_k;
        end else begin
          x_d[l] = x_q[k][l] + (y_q[k][l] >>> k);
          y_d[l] = y_q[k][l] - (x_q[k][l] >>> k);
          r_d[l] = r_q[k][l] + atan_k;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      tag_q[k+1]  <= tag_q[k];
      flip_q[k+1] <= flip_q[k];
      for (int l = 0; l < TRIG_LANES; l++) begin
        x_q[k+1][l] <= x_d[l];
        y_q[k+1][l] <= y_d[l];
        r_q[k+1][l] <= r_d[l];
      end
    end
  end

  // undo the fold, round and saturate
  logic [TRIG_LANES-1:0][Q15_W-1:0] sin_d, cos_d;

  always_comb begin
    logic signed [CORDIC_W-1:0] xf;
    logic signed [CORDIC_W-1:0] yf;
    for (int l = 0; l < TRIG_LANES; l++) begin
      xf       = flip_q[CORDIC_STEPS][l] ? -x_q[CORDIC_STEPS][l] : x_q[CORDIC_STEPS][l];
      yf       = flip_q[CORDIC_STEPS][l] ? -y_q[CORDIC_STEPS][l] : y_q[CORDIC_STEPS][l];
      cos_d[l] = to_q15(xf);
      sin_d[l] = to_q15(yf);
    end
  end

  logic valid_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_out_q <= 1'b0;
    end else begin
      valid_out_q <= valid_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    sin_o <= sin_d;
    cos_o <= cos_d;
    tag_o <= tag_q[CORDIC_STEPS];
  end

  assign out_valid_o = valid_out_q;

endmodule

[sv/uvs_back.sv]
// uvs_back: trig evaluation, radius scaling and the result register
// depends on uvs_pkg and uvs_cordic

module uvs_back #(
  parameter int unsigned TRIG_BITS = uvs_pkg::TRIG_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  input  uvs_pkg::tag_t                                 tag_i,
  input  logic [uvs_pkg::TRIG_LANES-1:0][TRIG_BITS-1:0] phase_i,
  input  logic [uvs_pkg::RAD_W-1:0]                     radius_i,
  output logic                                          done_o,
  output logic                                          valid_res_o,
  output logic signed [uvs_pkg::POS_W-1:0]              pos_x_o,
  output logic signed [uvs_pkg::POS_W-1:0]              pos_y_o,
  output logic signed [uvs_pkg::POS_W-1:0]              pos_z_o,
  output logic [uvs_pkg::IDX_W-1:0]                     corner_a_o,
  output logic [uvs_pkg::IDX_W-1:0]                     corner_b_o,
  output logic [uvs_pkg::IDX_W-1:0]                     corner_c_o
);
  import uvs_pkg::*;

  localparam int unsigned TAG_W = $bits(tag_t);

  // lane 0 longitude, lane 1 ring height, lane 2 ring radius
  logic                             cd_valid;
  logic [TRIG_LANES-1:0][Q15_W-1:0] cd_sin, cd_cos;
  logic [TAG_W-1:0]                 cd_tag;

  uvs_cordic #(
    .TRIG_BITS (TRIG_BITS),
    .TAG_W     (TAG_W)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .phase_i     (phase_i),
    .tag_i       (tag_i),
    .out_valid_o (cd_valid),
    .sin_o       (cd_sin),
    .cos_o       (cd_cos),
    .tag_o       (cd_tag)
  );

  // first products
  logic signed [RAD_W:0]  rad_s;
  logic                   m_valid_q;
  tag_t                   m_tag_q;
  logic signed [31:0]     px_q, pz_q;
  logic signed [33:0]     py_q;

  assign rad_s = $signed({1'b0, radius_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= cd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    m_tag_q <= tag_t'(cd_tag);
    px_q    <= 32'($signed(cd_sin[0])) * 32'($signed(cd_sin[2]));
    pz_q    <= 32'($signed(cd_cos[0])) * 32'($signed(cd_sin[2]));
    py_q    <= 34'(rad_s) * 34'($signed(cd_cos[1]));
  end

  // radius scaling with round half up
  logic signed [48:0] xr, zr;
  logic signed [33:0] yr;

  always_comb begin
    xr = (49'(rad_s) * 49'(px_q)) + (49'sd1 <<< 29);
    zr = (49'(rad_s) * 49'(pz_q)) + (49'sd1 <<< 29);
    yr = py_q + (34'sd1 <<< 14);
  end

  // result register, fields chosen by kind
  logic                     done_q, valid_res_q;
  logic signed [POS_W-1:0]  pos_x_q, pos_y_q, pos_z_q;
  logic [IDX_W-1:0]         ca_q, cb_q, cc_q;
  logic                     valid_res_d;
  logic signed [POS_W-1:0]  pos_x_d, pos_y_d, pos_z_d;
  logic [IDX_W-1:0]         ca_d, cb_d, cc_d;

  always_comb begin
    valid_res_d = 1'b1;
    pos_x_d     = '0;
    pos_y_d     = '0;
    pos_z_d     = '0;
    ca_d        = '0;
    cb_d        = '0;
    cc_d        = '0;
    unique case (m_tag_q.kind)
      KIND_TOP:  pos_y_d = rad_s;
      KIND_BOT:  pos_y_d = -rad_s;
      KIND_RING: begin
        pos_x_d = xr[46:30];
        pos_y_d = yr[31:15];
        pos_z_d = zr[46:30];
      end
      KIND_TRI: begin
        ca_d = m_tag_q.corner_a;
        cb_d = m_tag_q.corner_b;
        cc_d = m_tag_q.corner_c;
      end
      default:   valid_res_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    valid_res_q <= valid_res_d;
    pos_x_q     <= pos_x_d;
    pos_y_q     <= pos_y_d;
    pos_z_q     <= pos_z_d;
    ca_q        <= ca_d;
    cb_q        <= cb_d;
    cc_q        <= cc_d;
  end

  assign done_o      = done_q;
  assign valid_res_o = valid_res_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign pos_z_o     = pos_z_q;
  assign corner_a_o  = ca_q;
  assign corner_b_o  = cb_q;
  assign corner_c_o  = cc_q;

endmodule

[sv/uv_sphere_mesh_generator.sv]
// uv_sphere_mesh_generator: top level, configuration registers and front/back wiring
// depends on uvs_pkg, uvs_front, uvs_queue, uvs_back
//
//  channel   handshake          word
//  request   start / busy       op_i, element_number_i
//  config    cfg_we_i           cfg_idx_i, cfg_wdata_i
//  result    done_o (strobe)    valid_res_o, pos_x/y/z_o, corner_a/b/c_o
//
// one request is taken every cycle; busy never rises
// a request passes through the two pipelined dividers (element split and angle
// quantisation) and the 24-stage cordic
// every request gives exactly one result, in order, one cycle wide
// reset clears the pipeline valids and loads the register defaults
// the receiver cannot stall, so the queue drains every cycle

module uv_sphere_mesh_generator #(
  parameter int unsigned TRIG_TABLE_BITS = uvs_pkg::TRIG_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              op_i,
  input  logic [uvs_pkg::ELEM_W-1:0]        element_number_i,
  input  logic                              cfg_we_i,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [uvs_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output logic                              done_o,
  output logic                              valid_res_o,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_x_o,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_y_o,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_z_o,
  output logic [uvs_pkg::IDX_W-1:0]         corner_a_o,
  output logic [uvs_pkg::IDX_W-1:0]         corner_b_o,
  output logic [uvs_pkg::IDX_W-1:0]         corner_c_o
);
  import uvs_pkg::*;

  localparam int unsigned PH_W   = TRIG_LANES * TRIG_TABLE_BITS;
  localparam int unsigned TAG_W  = $bits(tag_t);
  localparam int unsigned WORD_W = TAG_W + PH_W;

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slices <= SLICES_RST;
      cfg_q.stacks <= STACKS_RST;
      cfg_q.radius <= RADIUS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SLICES: cfg_q.slices <= cfg_wdata_i[CNT_W-1:0];
        REG_STACKS: cfg_q.stacks <= cfg_wdata_i[CNT_W-1:0];
        REG_RADIUS: cfg_q.radius <= cfg_wdata_i[RAD_W-1:0];
        default:    ;
      endcase
    end
  end

  assign busy = 1'b0;

  // front half
  logic                                         fr_valid;
  tag_t                                         fr_tag;
  logic [TRIG_LANES-1:0][TRIG_TABLE_BITS-1:0]   fr_phase;

  uvs_front #(
    .TRIG_BITS (TRIG_TABLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start && !busy),
    .op_i        (op_i),
    .elem_i      (element_number_i),
    .cfg_i       (cfg_q),
    .out_valid_o (fr_valid),
    .out_tag_o   (fr_tag),
    .out_phase_o (fr_phase)
  );

  // decoupling queue
  logic                                         q_valid;
  logic [WORD_W-1:0]                            q_word;
  tag_t                                         bk_tag;
  logic [TRIG_LANES-1:0][TRIG_TABLE_BITS-1:0]   bk_phase;

  uvs_queue #(
    .DATA_W (WORD_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fr_valid),
    .data_i      ({fr_tag, fr_phase}),
    .ready_i     (1'b1),
    .out_valid_o (q_valid),
    .data_o      (q_word)
  );

  assign bk_tag   = tag_t'(q_word[WORD_W-1:PH_W]);
  assign bk_phase = q_word[PH_W-1:0];

  // back half
  uvs_back #(
    .TRIG_BITS (TRIG_TABLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .tag_i       (bk_tag),
    .phase_i     (bk_phase),
    .radius_i    (cfg_q.radius),
    .done_o      (done_o),
    .valid_res_o (valid_res_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .pos_z_o     (pos_z_o),
    .corner_a_o  (corner_a_o),
    .corner_b_o  (corner_b_o),
    .corner_c_o  (corner_c_o)
  );

endmodule
